FILE: rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped frame deframer with checksum.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam logic [7:0] BYTE_HEAD = 8'h5B;
    localparam logic [7:0] BYTE_ESC  = 8'h5C;
    localparam logic [7:0] BYTE_TAIL = 8'h5D;
    localparam logic [7:0] ESC_ESC   = 8'h00;
    localparam logic [7:0] ESC_HEAD  = 8'h01;
    localparam logic [7:0] ESC_TAIL  = 8'h02;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADTAIL = 3'd1;
    localparam logic [2:0] ST_ESCAPE   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] payload_byte;
        logic [2:0] frame_status;
    } t_out_item;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_TAIL = 1'b1
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic       bad_headtail;
        logic       bad_escape;
    } t_op;

endpackage

FILE: rtl/escaped_frame_deframer_checksum.sv
// A tail byte's status passes through the op queue and then the result queue to o_item.
// Payload bytes wait for two later unescaped bytes, then go through the result queue.
// Throughput: one input byte per cycle while full is low.
// Reset: synchronous, active low; clears frame state and both queues, no clearing pass.
// ----------------------------------------------------------------------------
// escaped_frame_deframer_checksum
// Byte-stuffed frame deframer with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_checksum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  efd_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output efd_pkg::t_out_item o_item
);

    logic         op_valid;
    logic         op_take;
    efd_pkg::t_op op;

    efd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_op_valid (op_valid),
        .i_op_take  (op_take),
        .o_op       (op)
    );

    efd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_take  (op_take),
        .i_op       (op),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item)
    );

endmodule

FILE: rtl/efd_front.sv
// ----------------------------------------------------------------------------
// efd_front
// Byte classifier: head/tail checks, unescaping, and a two-entry op queue.
// ----------------------------------------------------------------------------
module efd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  efd_pkg::t_in_item i_item,
    output logic              o_op_valid,
    input  logic              i_op_take,
    output efd_pkg::t_op      o_op
);

    logic r_at_start, n_at_start;
    logic r_esc_pend, n_esc_pend;
    logic r_esc_err,  n_esc_err;
    logic r_head_err, n_head_err;

    efd_pkg::t_op r_mem [efd_pkg::QUEUE_DEPTH];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    logic         accept;
    logic         op_emit;
    efd_pkg::t_op op_new;
    logic [7:0]   b;

    assign full       = (r_count == 2'(efd_pkg::QUEUE_DEPTH));
    assign accept     = push && !full;
    assign o_op_valid = (r_count != 2'd0);
    assign o_op       = r_mem[r_rd_ptr];
    assign b          = i_item.in_byte;

    always_comb begin
        n_at_start          = r_at_start;
        n_esc_pend          = r_esc_pend;
        n_esc_err           = r_esc_err;
        n_head_err          = r_head_err;
        op_emit             = 1'b0;
        op_new.kind         = efd_pkg::OP_DATA;
        op_new.data         = b;
        op_new.bad_headtail = 1'b0;
        op_new.bad_escape   = 1'b0;
        if (r_at_start) begin
            n_at_start = 1'b0;
            n_esc_pend = 1'b0;
            n_esc_err  = 1'b0;
            n_head_err = (b != efd_pkg::BYTE_HEAD);
            if (i_item.frame_last) begin
                op_emit             = 1'b1;
                op_new.kind         = efd_pkg::OP_TAIL;
                op_new.bad_headtail = 1'b1;
                n_at_start          = 1'b1;
            end
        end else if (i_item.frame_last) begin
            op_emit             = 1'b1;
            op_new.kind         = efd_pkg::OP_TAIL;
            op_new.bad_headtail = (b != efd_pkg::BYTE_TAIL) || r_head_err;
            op_new.bad_escape   = r_esc_err || r_esc_pend;
            n_at_start          = 1'b1;
            n_esc_pend          = 1'b0;
            n_esc_err           = 1'b0;
            n_head_err          = 1'b0;
        end else if (r_esc_err) begin
            op_emit = 1'b0;
        end else if (r_esc_pend) begin
            n_esc_pend = 1'b0;
            priority if (b == efd_pkg::ESC_ESC) begin
                op_emit     = !r_head_err;
                op_new.data = efd_pkg::BYTE_ESC;
            end else if (b == efd_pkg::ESC_HEAD) begin
                op_emit     = !r_head_err;
                op_new.data = efd_pkg::BYTE_HEAD;
            end else if (b == efd_pkg::ESC_TAIL) begin
                op_emit     = !r_head_err;
                op_new.data = efd_pkg::BYTE_TAIL;
            end else begin
                n_esc_err = 1'b1;
            end
        end else if (b == efd_pkg::BYTE_ESC) begin
            n_esc_pend = 1'b1;
        end else begin
            op_emit = !r_head_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_esc_pend <= 1'b0;
            r_esc_err  <= 1'b0;
            r_head_err <= 1'b0;
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_count    <= 2'd0;
        end else begin
            if (accept) begin
                r_at_start <= n_at_start;
                r_esc_pend <= n_esc_pend;
                r_esc_err  <= n_esc_err;
                r_head_err <= n_head_err;
            end
            if (accept && op_emit) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_op_take && o_op_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(accept && op_emit) - 2'(i_op_take && o_op_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && op_emit) begin
            r_mem[r_wr_ptr] <= op_new;
        end
    end

endmodule

FILE: rtl/efd_back.sv
// ----------------------------------------------------------------------------
// efd_back
// Op executor: two-byte hold, 16-bit running sum, status, result queue.
// ----------------------------------------------------------------------------
module efd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    output logic               o_op_take,
    input  efd_pkg::t_op       i_op,
    output logic               empty,
    input  logic               pop,
    output efd_pkg::t_out_item o_item
);

    logic [7:0]  r_held [2];
    logic [1:0]  r_held_cnt;
    logic [15:0] r_sum;

    efd_pkg::t_out_item r_mem [efd_pkg::QUEUE_DEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    logic               res_full;
    logic               fire;
    logic               res_emit;
    logic               res_pop;
    efd_pkg::t_out_item res_new;
    logic [2:0]         status;

    assign res_full  = (r_count == 2'(efd_pkg::QUEUE_DEPTH));
    assign empty     = (r_count == 2'd0);
    assign res_pop   = pop && !empty;
    assign o_item    = r_mem[r_rd_ptr];
    assign fire      = i_op_valid && !res_full;
    assign o_op_take = fire;

    always_comb begin
        priority if (i_op.bad_headtail) begin
            status = efd_pkg::ST_HEADTAIL;
        end else if (i_op.bad_escape) begin
            status = efd_pkg::ST_ESCAPE;
        end else if (r_held_cnt != 2'd2) begin
            status = efd_pkg::ST_SHORT;
        end else if ({r_held[1], r_held[0]} == r_sum) begin
            status = efd_pkg::ST_OK;
        end else begin
            status = efd_pkg::ST_CHECKSUM;
        end
    end

    always_comb begin
        if (i_op.kind == efd_pkg::OP_TAIL) begin
            res_emit             = 1'b1;
            res_new.out_kind     = efd_pkg::KIND_STATUS;
            res_new.payload_byte = 8'h00;
            res_new.frame_status = status;
        end else begin
            res_emit             = (r_held_cnt == 2'd2);
            res_new.out_kind     = efd_pkg::KIND_PAYLOAD;
            res_new.payload_byte = r_held[0];
            res_new.frame_status = efd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_sum      <= 16'h0000;
            r_held[0]  <= 8'h00;
            r_held[1]  <= 8'h00;
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_count    <= 2'd0;
        end else begin
            if (fire) begin
                if (i_op.kind == efd_pkg::OP_TAIL) begin
                    r_held_cnt <= 2'd0;
                    r_sum      <= 16'h0000;
                    r_held[0]  <= 8'h00;
                    r_held[1]  <= 8'h00;
                end else if (r_held_cnt == 2'd2) begin
                    r_sum     <= r_sum + {8'h00, r_held[0]};
                    r_held[0] <= r_held[1];
                    r_held[1] <= i_op.data;
                end else begin
                    r_held[r_held_cnt[0]] <= i_op.data;
                    r_held_cnt            <= r_held_cnt + 2'd1;
                end
            end
            if (fire && res_emit) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (res_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(fire && res_emit) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_emit) begin
            r_mem[r_wr_ptr] <= res_new;
        end
    end

    a_held_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("hold count out of range");

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overflow");

    a_tail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_op.kind == efd_pkg::OP_TAIL) |=> (r_held_cnt == 2'd0 && r_sum == 16'h0000))
        else $error("frame state not cleared after tail");

    a_tail_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_op.kind == efd_pkg::OP_TAIL) |=> !empty)
        else $error("tail transaction produced no status");

endmodule

FILE: tb/tb_escaped_frame_deframer_checksum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_deframer_checksum
// Self-checking bench for the byte-stuffed frame deframer. Directed frames
// hit every status but checksum, then random frames (mostly well formed, some
// corrupted) run under three sender/receiver idle mixes. A scoreboard predicts
// every payload and status transaction and checks the outputs in order.
// ----------------------------------------------------------------------------
module tb_escaped_frame_deframer_checksum;

    localparam int ITEMS_PER_PHASE = 584;
    localparam int WATCHDOG_LIMIT  = 2000;

    class frame_scoreboard;
        bit                 at_start;
        bit                 esc_pend;
        bit                 head_err;
        bit                 esc_err;
        logic [7:0]         held [2];
        logic [1:0]         held_cnt;
        logic [15:0]        sum;
        efd_pkg::t_out_item expected_q[$];
        int unsigned        errors;

        function new();
            at_start = 1'b1;
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            esc_pend = 1'b0;
            head_err = 1'b0;
            esc_err  = 1'b0;
            held[0]  = '0;
            held[1]  = '0;
            held_cnt = '0;
            sum      = '0;
        endfunction

        function void close_frame(logic [2:0] st);
            efd_pkg::t_out_item r;
            r.out_kind     = efd_pkg::KIND_STATUS;
            r.payload_byte = '0;
            r.frame_status = st;
            expected_q.push_back(r);
            at_start = 1'b1;
            clear_frame();
        endfunction

        function void push_unescaped(logic [7:0] u);
            efd_pkg::t_out_item r;
            if (held_cnt >= 2) begin
                r.out_kind     = efd_pkg::KIND_PAYLOAD;
                r.payload_byte = held[0];
                r.frame_status = efd_pkg::ST_OK;
                sum     = sum + 16'(held[0]);
                held[0] = held[1];
                held[1] = u;
                if (!head_err) expected_q.push_back(r);
            end else begin
                held[held_cnt[0]] = u;
                held_cnt = held_cnt + 1'b1;
            end
        endfunction

        function void note_input(efd_pkg::t_in_item it);
            logic [7:0] b;
            logic [2:0] st;
            b = it.in_byte;
            if (at_start) begin
                clear_frame();
                at_start = 1'b0;
                if (b != efd_pkg::BYTE_HEAD) head_err = 1'b1;
                if (it.frame_last) close_frame(efd_pkg::ST_HEADTAIL);
                return;
            end
            if (it.frame_last) begin
                if (b != efd_pkg::BYTE_TAIL || head_err) st = efd_pkg::ST_HEADTAIL;
                else if (esc_err || esc_pend) st = efd_pkg::ST_ESCAPE;
                else if (held_cnt < 2) st = efd_pkg::ST_SHORT;
                else if ({held[1], held[0]} == sum) st = efd_pkg::ST_OK;
                else st = efd_pkg::ST_CHECKSUM;
                close_frame(st);
                return;
            end
            if (esc_err) return;
            if (esc_pend) begin
                esc_pend = 1'b0;
                case (b)
                    efd_pkg::ESC_ESC:  push_unescaped(efd_pkg::BYTE_ESC);
                    efd_pkg::ESC_HEAD: push_unescaped(efd_pkg::BYTE_HEAD);
                    efd_pkg::ESC_TAIL: push_unescaped(efd_pkg::BYTE_TAIL);
                    default:           esc_err = 1'b1;
                endcase
                return;
            end
            if (b == efd_pkg::BYTE_ESC) esc_pend = 1'b1;
            else push_unescaped(b);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(efd_pkg::t_out_item got);
            efd_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected transaction: expected none actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_kind !== want.out_kind)
                report("out_kind", want.out_kind, got.out_kind);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", want.payload_byte, got.payload_byte);
            if (got.frame_status !== want.frame_status)
                report("frame_status", want.frame_status, got.frame_status);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    efd_pkg::t_in_item  i_item;
    logic               empty;
    logic               pop;
    efd_pkg::t_out_item o_item;

    frame_scoreboard sb = new();

    logic [7:0]  frame_q[$];
    logic [15:0] frame_sum;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          sent_count;
    int          idle_cycles;

    escaped_frame_deframer_checksum u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_input(i_item);
            if (pop && !empty) sb.check_result(o_item);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return efd_pkg::BYTE_HEAD;
            1:       return efd_pkg::BYTE_ESC;
            2:       return efd_pkg::BYTE_TAIL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_escaped(logic [7:0] b);
        if (b == efd_pkg::BYTE_ESC) begin
            frame_q.push_back(efd_pkg::BYTE_ESC);
            frame_q.push_back(efd_pkg::ESC_ESC);
        end else if (b == efd_pkg::BYTE_HEAD) begin
            frame_q.push_back(efd_pkg::BYTE_ESC);
            frame_q.push_back(efd_pkg::ESC_HEAD);
        end else if (b == efd_pkg::BYTE_TAIL) begin
            frame_q.push_back(efd_pkg::BYTE_ESC);
            frame_q.push_back(efd_pkg::ESC_TAIL);
        end else begin
            frame_q.push_back(b);
        end
    endfunction

    function automatic void add_payload(logic [7:0] b);
        add_escaped(b);
        frame_sum = frame_sum + 16'(b);
    endfunction

    function automatic void add_checksum(logic [15:0] ck);
        add_escaped(ck[7:0]);
        add_escaped(ck[15:8]);
    endfunction

    task automatic send_item(efd_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_frame();
        efd_pkg::t_in_item it;
        for (int k = 0; k < frame_q.size(); k++) begin
            it.in_byte    = frame_q[k];
            it.frame_last = (k == frame_q.size() - 1);
            send_item(it);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic build_random_frame();
        int          pick;
        int          len;
        int          pos;
        logic [15:0] ck;
        logic [7:0]  tail;
        frame_q.delete();
        frame_sum = '0;
        pick = $urandom_range(0, 99);
        if (pick >= 95) begin
            len = $urandom_range(1, 6);
            repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        frame_q.push_back(efd_pkg::BYTE_HEAD);
        if (pick >= 90) begin
            len = $urandom_range(0, 1);
            repeat (len) add_payload(pick_payload());
            frame_q.push_back(efd_pkg::BYTE_TAIL);
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (len) add_payload(pick_payload());
        ck = frame_sum;
        if (pick >= 66 && pick < 74) ck = ck ^ (16'h0001 << $urandom_range(0, 15));
        add_checksum(ck);
        if (pick >= 74 && pick < 79)
            frame_q[0] = efd_pkg::BYTE_HEAD ^ 8'($urandom_range(1, 255));
        tail = efd_pkg::BYTE_TAIL;
        if (pick >= 79 && pick < 83) tail = efd_pkg::BYTE_TAIL ^ 8'($urandom_range(1, 255));
        if (pick >= 83 && pick < 87) begin
            pos = $urandom_range(1, frame_q.size());
            frame_q.insert(pos, efd_pkg::BYTE_ESC);
            frame_q.insert(pos + 1, 8'($urandom_range(3, 255)));
        end
        if (pick >= 87 && pick < 90) frame_q.push_back(efd_pkg::BYTE_ESC);
        frame_q.push_back(tail);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_item         = '0;
        send_idle_pct  = 6;
        recv_stall_pct = 45;
        sent_count     = 0;
        idle_cycles    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // head that is also the tail
        frame_q = '{efd_pkg::BYTE_HEAD};
        send_frame();
        // bad head, payload dropped and a head/tail status reported
        frame_q = '{8'hFF, 8'h12, 8'h34, 8'h56, efd_pkg::BYTE_TAIL};
        send_frame();
        // too short
        frame_q = '{efd_pkg::BYTE_HEAD, efd_pkg::BYTE_TAIL};
        send_frame();
        // escape right before tail
        frame_q = '{efd_pkg::BYTE_HEAD, efd_pkg::BYTE_ESC, efd_pkg::BYTE_TAIL};
        send_frame();
        // invalid escape code
        frame_q = '{efd_pkg::BYTE_HEAD, efd_pkg::BYTE_ESC, 8'h03, efd_pkg::BYTE_TAIL};
        send_frame();
        // good frame using every escape plus byte extremes
        frame_q = '{efd_pkg::BYTE_HEAD};
        frame_sum = '0;
        add_payload(efd_pkg::BYTE_ESC);
        add_payload(efd_pkg::BYTE_HEAD);
        add_payload(efd_pkg::BYTE_TAIL);
        add_payload(8'h00);
        add_payload(8'hFF);
        add_checksum(frame_sum);
        frame_q.push_back(efd_pkg::BYTE_TAIL);
        send_frame();

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            send_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 45 : 0;
            recv_stall_pct = (ph == 0) ? 45 : (ph == 1) ? 6 : 0;
            sent_count = 0;
            while (sent_count < ITEMS_PER_PHASE) begin
                build_random_frame();
                send_frame();
                if ($urandom_range(0, 39) == 0) drain();
            end
        end
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
